FILE: rtl/qph_pkg.sv
package qph_pkg;

  localparam int TableSize = 1024;
  localparam int AddrW     = $clog2(TableSize);
  localparam int CntW      = AddrW + 1;
  localparam int KeyW      = 31;
  localparam int OpW       = 2;
  localparam int StW       = 2;
  localparam int MarkW     = 2;

  localparam logic [OpW-1:0] OpInsert = 2'd0;
  localparam logic [OpW-1:0] OpSearch = 2'd1;
  localparam logic [OpW-1:0] OpDelete = 2'd2;

  localparam logic [StW-1:0] StOk      = 2'd0;
  localparam logic [StW-1:0] StMissing = 2'd1;
  localparam logic [StW-1:0] StFull    = 2'd2;

  localparam logic [MarkW-1:0] MarkEmpty = 2'd0;
  localparam logic [MarkW-1:0] MarkUsed  = 2'd1;
  localparam logic [MarkW-1:0] MarkGone  = 2'd2;

  localparam int ProbeLin  = 7;
  localparam int ProbeQuad = 13;
  localparam logic [AddrW-1:0] FirstStep = AddrW'(ProbeLin + ProbeQuad);
  localparam logic [AddrW-1:0] StepInc   = AddrW'(2 * ProbeQuad);

  localparam logic [CntW-1:0] FillReset = 11'd972;

  typedef struct packed {
    logic [MarkW-1:0] mark;
    logic [KeyW-1:0]  key;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    entry_t           wdata;
    logic [AddrW-1:0] raddr;
  } tbl_req_t;

endpackage

FILE: rtl/qph_req_if.sv
interface qph_req_if;
  import qph_pkg::*;
  logic            valid;
  logic            ready;
  logic [OpW-1:0]  opcode;
  logic [KeyW-1:0] key;
  modport source (output valid, opcode, key, input ready);
  modport sink   (input valid, opcode, key, output ready);
endinterface

FILE: rtl/qph_rsp_if.sv
interface qph_rsp_if;
  import qph_pkg::*;
  logic             valid;
  logic             ready;
  logic [StW-1:0]   status;
  logic [AddrW-1:0] slot;
  logic [CntW-1:0]  probes;
  modport source (output valid, status, slot, probes, input ready);
  modport sink   (input valid, status, slot, probes, output ready);
endinterface

FILE: rtl/qph_cfg_if.sv
interface qph_cfg_if;
  import qph_pkg::*;
  logic            valid;
  logic            ready;
  logic [CntW-1:0] fill_limit;
  modport source (output valid, fill_limit, input ready);
  modport sink   (input valid, fill_limit, output ready);
endinterface

FILE: rtl/qph_table_mem.sv
module qph_table_mem
  import qph_pkg::*;
(
  input  logic     clk_i,
  input  tbl_req_t req_i,
  output entry_t   rdata_o
);

  entry_t mem [TableSize];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[req_i.raddr];
  end

endmodule

FILE: rtl/qph_ctrl.sv
module qph_ctrl
  import qph_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [CntW-1:0] fill_limit_i,
  qph_req_if.sink         req,
  qph_rsp_if.source       rsp,
  output tbl_req_t        tbl_o,
  input  entry_t          rdata_i
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_FINISH
  } state_e;

  state_e           state_q, state_d;
  logic [AddrW-1:0] clr_q, clr_d;
  logic [AddrW-1:0] pos_q, pos_d;
  logic [AddrW-1:0] step_q, step_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CntW-1:0]  occ_q, occ_d;
  logic [OpW-1:0]   op_q, op_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [StW-1:0]   res_st_q, res_st_d;
  logic [AddrW-1:0] res_slot_q, res_slot_d;
  logic [CntW-1:0]  res_cnt_q, res_cnt_d;
  logic             out_vld_q, out_vld_d;
  logic [StW-1:0]   out_st_q, out_st_d;
  logic [AddrW-1:0] out_slot_q, out_slot_d;
  logic [CntW-1:0]  out_cnt_q, out_cnt_d;

  logic accept, is_used, is_match, term, success, last;

  assign req.ready  = (state_q == S_IDLE);
  assign accept     = req.valid && req.ready;
  assign rsp.valid  = out_vld_q;
  assign rsp.status = out_st_q;
  assign rsp.slot   = out_slot_q;
  assign rsp.probes = out_cnt_q;

  assign is_used  = (rdata_i.mark == MarkUsed);
  assign is_match = is_used && (rdata_i.key == key_q);
  assign last     = (cnt_q == CntW'(TableSize));

  always_comb begin
    if (op_q == OpInsert) begin
      term    = !is_used;
      success = !is_used;
    end else begin
      term    = is_match || (rdata_i.mark == MarkEmpty);
      success = is_match;
    end
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    pos_d      = pos_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    occ_d      = occ_q;
    op_d       = op_q;
    key_d      = key_q;
    res_st_d   = res_st_q;
    res_slot_d = res_slot_q;
    res_cnt_d  = res_cnt_q;
    out_vld_d  = out_vld_q && !rsp.ready;
    out_st_d   = out_st_q;
    out_slot_d = out_slot_q;
    out_cnt_d  = out_cnt_q;

    tbl_o.we    = 1'b0;
    tbl_o.waddr = pos_q;
    tbl_o.wdata = '{mark: MarkUsed, key: key_q};
    tbl_o.raddr = pos_q + step_q;

    unique case (state_q)
      S_CLEAR: begin
        tbl_o.we    = 1'b1;
        tbl_o.waddr = clr_q;
        tbl_o.wdata = '{mark: MarkEmpty, key: '0};
        clr_d       = clr_q + 1'b1;
        if (clr_q == AddrW'(TableSize - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        tbl_o.raddr = req.key[AddrW-1:0];
        if (accept) begin
          op_d   = req.opcode;
          key_d  = req.key;
          pos_d  = req.key[AddrW-1:0];
          step_d = FirstStep;
          cnt_d  = CntW'(1);
          if (req.opcode == OpInsert && occ_q >= fill_limit_i) begin
            res_st_d   = StFull;
            res_slot_d = '0;
            res_cnt_d  = '0;
            state_d    = S_FINISH;
          end else if (req.opcode == OpInsert || req.opcode == OpSearch ||
                       req.opcode == OpDelete) begin
            state_d = S_PROBE;
          end else begin
            res_st_d   = StMissing;
            res_slot_d = '0;
            res_cnt_d  = '0;
            state_d    = S_FINISH;
          end
        end
      end
      S_PROBE: begin
        if (term || last) begin
          res_cnt_d = cnt_q;
          state_d   = S_FINISH;
          if (success) begin
            res_st_d   = StOk;
            res_slot_d = pos_q;
            if (op_q == OpInsert) begin
              tbl_o.we = 1'b1;
              occ_d    = occ_q + 1'b1;
            end else if (op_q == OpDelete) begin
              tbl_o.we    = 1'b1;
              tbl_o.wdata = '{mark: MarkGone, key: rdata_i.key};
              if (occ_q != '0) begin
                occ_d = occ_q - 1'b1;
              end
            end
          end else begin
            res_st_d   = (op_q == OpInsert) ? StFull : StMissing;
            res_slot_d = '0;
          end
        end else begin
          pos_d  = pos_q + step_q;
          step_d = step_q + StepInc;
          cnt_d  = cnt_q + 1'b1;
        end
      end
      S_FINISH: begin
        if (!out_vld_q || rsp.ready) begin
          out_vld_d  = 1'b1;
          out_st_d   = res_st_q;
          out_slot_d = res_slot_q;
          out_cnt_d  = res_cnt_q;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      pos_q      <= '0;
      step_q     <= '0;
      cnt_q      <= '0;
      occ_q      <= '0;
      op_q       <= '0;
      key_q      <= '0;
      res_st_q   <= '0;
      res_slot_q <= '0;
      res_cnt_q  <= '0;
      out_vld_q  <= 1'b0;
      out_st_q   <= '0;
      out_slot_q <= '0;
      out_cnt_q  <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      pos_q      <= pos_d;
      step_q     <= step_d;
      cnt_q      <= cnt_d;
      occ_q      <= occ_d;
      op_q       <= op_d;
      key_q      <= key_d;
      res_st_q   <= res_st_d;
      res_slot_q <= res_slot_d;
      res_cnt_q  <= res_cnt_d;
      out_vld_q  <= out_vld_d;
      out_st_q   <= out_st_d;
      out_slot_q <= out_slot_d;
      out_cnt_q  <= out_cnt_d;
    end
  end

endmodule

FILE: rtl/quadratic_probe_hash_table.sv
// Open-addressing hash table of 31-bit keys with quadratic probing.
// Requests arrive on req_i (opcode and key) and each yields one response
// transaction on rsp_o (status, slot and probe count). The fill limit is
// written through cfg_i, which is always ready; write it only while idle.
// The response becomes valid once the probe walk has ended and its result
// has passed through the result registers to the output register; the probe
// walk reads the table memory once per cycle, the next slot being computed
// by running sums. An insert refused at the fill limit, and an unused
// opcode, skip the probe walk and go straight to the finishing state. One
// request is processed at a time; the next request is accepted once the
// previous result has moved to the output register.
// After reset the block sweeps the table memory to mark every slot empty,
// and accepts no request meanwhile. If the receiver stalls, the result
// waits in the output register and a further finished result waits in the
// controller until that register is free.
module quadratic_probe_hash_table
  import qph_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  qph_req_if.sink   req_i,
  qph_rsp_if.source rsp_o,
  qph_cfg_if.sink   cfg_i
);

  logic [CntW-1:0] fill_limit_q;
  tbl_req_t        tbl_req;
  entry_t          tbl_rdata;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_limit_q <= FillReset;
    end else if (cfg_i.valid) begin
      fill_limit_q <= cfg_i.fill_limit;
    end
  end

  qph_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fill_limit_i (fill_limit_q),
    .req          (req_i),
    .rsp          (rsp_o),
    .tbl_o        (tbl_req),
    .rdata_i      (tbl_rdata)
  );

  qph_table_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

endmodule
